>>> hw/rtl/idea_pkg.sv
// idea_pkg: shared constants and subkey selection for the block cipher pipeline
// no dependencies; used by idea_mulmod, idea_round, idea_out and idea_block_encrypt
package idea_pkg;

    localparam int ROUNDS     = 8;
    localparam int SUBKEYS    = 52;
    localparam int KEY_ROTATE = 25;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_KEY_UPPER = 2'd0,
        REG_KEY_LOWER = 2'd1
    } reg_index_t;

    typedef logic [15:0]      word_t;
    typedef logic [5:0][15:0] round_keys_t;
    typedef logic [3:0][15:0] out_keys_t;

    // 16-bit subkey at word position pos of the key rotated left by rot bits
    function automatic word_t subkey(input logic [127:0] key, input logic [6:0] rot,
                                     input logic [2:0] pos);
        logic [255:0] dbl;
        logic [127:0] rk;
        dbl = {key, key};
        rk  = 128'(dbl >> (8'd128 - {1'b0, rot}));
        return rk[(127 - 16 * int'(pos)) -: 16];
    endfunction

endpackage

>>> hw/rtl/idea_mulmod.sv
// idea_mulmod: multiplication modulo 65537 with zero standing for 65536
// uses idea_pkg for the word type
module idea_mulmod (
    input  idea_pkg::word_t x,
    input  idea_pkg::word_t y,
    output idea_pkg::word_t p
);

    logic [31:0] prod;
    logic [15:0] lo;
    logic [15:0] hi;

    assign prod = 32'(x) * 32'(y);
    assign lo   = prod[15:0];
    assign hi   = prod[31:16];

    // zero operand gives 1 - other, otherwise low minus high with wrap fix
    always_comb
    begin
        if (x == 16'd0)
        begin
            p = 16'd1 - y;
        end
        else if (y == 16'd0)
        begin
            p = 16'd1 - x;
        end
        else
        begin
            p = lo - hi + ((lo < hi) ? 16'd1 : 16'd0);
        end
    end

endmodule

>>> hw/rtl/idea_round.sv
// idea_round: one cipher round as three register stages with valid and ready
// depends on idea_pkg and idea_mulmod
module idea_round (
    input  logic                     clk,
    input  logic                     rst_n,
    input  idea_pkg::round_keys_t    keys,
    input  logic                     last,
    input  logic                     in_valid,
    input  logic [63:0]              in_data,
    output logic                     in_ready,
    output logic                     out_valid,
    output logic [63:0]              out_data,
    input  logic                     out_ready
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    idea_pkg::word_t a1_reg, b1_reg, c1_reg, d1_reg;
    idea_pkg::word_t a2_reg, b2_reg, c2_reg, d2_reg, t0_reg;
    logic [63:0] w_reg;
    idea_pkg::word_t a_mul, d_mul, t0_mul, t1_mul, t2;
    idea_pkg::word_t b_add, c_add, bd_sum;

    // stage ready chain: a stage moves when empty or the next one moves
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage one: input multiplies and adds
    idea_mulmod u_mul_a (.x(in_data[63:48]), .y(keys[0]), .p(a_mul));
    idea_mulmod u_mul_d (.x(in_data[15:0]),  .y(keys[3]), .p(d_mul));
    assign b_add = in_data[47:32] + keys[1];
    assign c_add = in_data[31:16] + keys[2];

    // stage two: first mixing multiply
    idea_mulmod u_mul_t0 (.x(a1_reg ^ c1_reg), .y(keys[4]), .p(t0_mul));

    // stage three: second mixing multiply and output xor
    assign bd_sum = (b2_reg ^ d2_reg) + t0_reg;
    idea_mulmod u_mul_t1 (.x(bd_sum), .y(keys[5]), .p(t1_mul));
    assign t2 = t0_reg + t1_mul;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            a1_reg <= a_mul;
            b1_reg <= b_add;
            c1_reg <= c_add;
            d1_reg <= d_mul;
        end
        if (rdy2)
        begin
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            c2_reg <= c1_reg;
            d2_reg <= d1_reg;
            t0_reg <= t0_mul;
        end
        if (rdy3)
        begin
            if (last)
                w_reg <= {a2_reg ^ t1_mul, b2_reg ^ t2, c2_reg ^ t1_mul, d2_reg ^ t2};
            else
                w_reg <= {a2_reg ^ t1_mul, c2_reg ^ t1_mul, b2_reg ^ t2, d2_reg ^ t2};
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = w_reg;

endmodule

>>> hw/rtl/idea_out.sv
// idea_out: output transform stage, also the result register
// depends on idea_pkg and idea_mulmod
module idea_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  idea_pkg::out_keys_t  keys,
    input  logic                 in_valid,
    input  logic [63:0]          in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    output logic [63:0]          out_data,
    input  logic                 out_ready
);

    logic v_reg;
    logic [63:0] y_reg;
    idea_pkg::word_t y0, y3;

    assign in_ready = !v_reg || out_ready;

    // outer multiplies and adds
    idea_mulmod u_mul_y0 (.x(in_data[63:48]), .y(keys[0]), .p(y0));
    idea_mulmod u_mul_y3 (.x(in_data[15:0]),  .y(keys[3]), .p(y3));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            y_reg <= {y0, in_data[47:32] + keys[1], in_data[31:16] + keys[2], y3};
    end

    assign out_valid = v_reg;
    assign out_data  = y_reg;

endmodule

>>> hw/rtl/idea_block_encrypt.sv
// idea_block_encrypt: pipelined block encryption, 64-bit blocks, 128-bit key
// depends on idea_pkg, idea_round, idea_out
//
//  channel   valid      stall      payload
//  input     in_valid   in_stall   plaintext
//  output    out_valid  out_stall  ciphertext
//  config    cfg_wr_en  -          cfg_index, cfg_value
//
// the pipeline has three stages per round (one per dependent multiply) for eight
// rounds plus the output transform stage; one block per cycle while out_stall is low.
// reset clears all stage valid bits and both key registers.
// an output stall holds the result; stages behind it keep filling bubbles,
// and in_stall rises only when every stage holds a transaction.
module idea_block_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_value,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] plaintext,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] ciphertext
);

    logic [63:0] key_upper_reg;
    logic [63:0] key_lower_reg;
    logic [127:0] key;
    idea_pkg::word_t subkeys [idea_pkg::SUBKEYS];
    idea_pkg::round_keys_t rkeys [idea_pkg::ROUNDS];
    idea_pkg::out_keys_t okeys;

    logic [idea_pkg::ROUNDS:0]        vld;
    logic [idea_pkg::ROUNDS:0]        rdy;
    logic [idea_pkg::ROUNDS:0][63:0]  dat;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= 64'd0;
            key_lower_reg <= 64'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                idea_pkg::REG_KEY_UPPER: key_upper_reg <= cfg_value;
                idea_pkg::REG_KEY_LOWER: key_lower_reg <= cfg_value;
                default: ;
            endcase
        end
    end

    assign key = {key_upper_reg, key_lower_reg};

    // subkey schedule is fixed wiring of the rotated key
    for (genvar n = 0; n < idea_pkg::SUBKEYS; n++)
    begin : g_subkey
        localparam int GRP = n / 8;
        localparam int POS = n % 8;
        localparam logic [6:0] ROT = 7'((idea_pkg::KEY_ROTATE * GRP) % 128);
        assign subkeys[n] = idea_pkg::subkey(key, ROT, 3'(POS));
    end

    // round pipeline
    assign vld[0]   = in_valid;
    assign dat[0]   = plaintext;
    assign in_stall = !rdy[0];

    for (genvar r = 0; r < idea_pkg::ROUNDS; r++)
    begin : g_round
        for (genvar i = 0; i < 6; i++)
        begin : g_key
            assign rkeys[r][i] = subkeys[6 * r + i];
        end
        idea_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .keys      (rkeys[r]),
            .last      (r == idea_pkg::ROUNDS - 1),
            .in_valid  (vld[r]),
            .in_data   (dat[r]),
            .in_ready  (rdy[r]),
            .out_valid (vld[r + 1]),
            .out_data  (dat[r + 1]),
            .out_ready (rdy[r + 1])
        );
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_okey
        assign okeys[i] = subkeys[6 * idea_pkg::ROUNDS + i];
    end

    // output transform and result register
    idea_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (okeys),
        .in_valid  (vld[idea_pkg::ROUNDS]),
        .in_data   (dat[idea_pkg::ROUNDS]),
        .in_ready  (rdy[idea_pkg::ROUNDS]),
        .out_valid (out_valid),
        .out_data  (ciphertext),
        .out_ready (!out_stall)
    );

endmodule

>>> hw/rtl/idea_chk.sv
// idea_chk: port-level checks for idea_block_encrypt, attached by bind
// no package dependencies
module idea_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] ciphertext
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(ciphertext))
        else $error("ciphertext changed while stalled");

    // a stalled input transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input valid dropped while stalled");

    // an open output lets every stage move
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled with output open");

    // input backpressure only with a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

endmodule

bind idea_block_encrypt idea_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ciphertext (ciphertext)
);

>>> tb/tb.sv
// tb: self-checking bench for idea_block_encrypt, random and directed blocks
// depends on idea_pkg and idea_block_encrypt; keeps its own cipher model
module tb;

    // expected ciphertext store and checker
    class cipher_board;
        logic [63:0] pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void note(logic [63:0] ct);
            pending.push_back(ct);
        endfunction

        // one line per mismatch, counted
        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(logic [63:0] ct);
            logic [63:0] want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected ciphertext %h", ct));
            end
            else
            begin
                want = pending.pop_front();
                if (want !== ct)
                begin
                    report($sformatf("ciphertext %h want %h", ct, want));
                end
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_value;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] plaintext;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] ciphertext;

    logic [63:0] key_hi, key_lo;
    int sender_idle, receiver_idle;
    bit hold_off;
    longint cycles;
    cipher_board board;

    idea_block_encrypt dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_value(cfg_value),
        .in_valid(in_valid), .in_stall(in_stall), .plaintext(plaintext),
        .out_valid(out_valid), .out_stall(out_stall), .ciphertext(ciphertext)
    );

    // multiplication modulo 65537, zero standing for 65536
    function automatic logic [15:0] mul_65537(logic [15:0] x, logic [15:0] y);
        logic [31:0] p;
        logic [15:0] lo, hi;
        if (x == 0)
            return 16'(17'd1 - y);
        if (y == 0)
            return 16'(17'd1 - x);
        p  = x * y;
        lo = p[15:0];
        hi = p[31:16];
        return lo - hi + (lo < hi ? 16'd1 : 16'd0);
    endfunction

    // full encryption of one block under the current key registers
    function automatic logic [63:0] encrypt_block(logic [63:0] blk);
        logic [15:0] z[52];
        logic [127:0] k;
        logic [15:0] w0, w1, w2, w3, a, b, c, d, t0, t1, t2;
        k = {key_hi, key_lo};
        for (int n = 0; n < 52; n++)
        begin
            if (n > 0 && n % 8 == 0)
                k = {k[102:0], k[127:103]};
            z[n] = k[127 - 16 * (n % 8) -: 16];
        end
        {w0, w1, w2, w3} = blk;
        for (int r = 0; r < 8; r++)
        begin
            a  = mul_65537(w0, z[r*6]);
            b  = w1 + z[r*6+1];
            c  = w2 + z[r*6+2];
            d  = mul_65537(w3, z[r*6+3]);
            t0 = mul_65537(a ^ c, z[r*6+4]);
            t1 = mul_65537((b ^ d) + t0, z[r*6+5]);
            t2 = t0 + t1;
            w0 = a ^ t1;
            w3 = d ^ t2;
            if (r != 7)
            begin
                w1 = c ^ t1;
                w2 = b ^ t2;
            end
            else
            begin
                w1 = b ^ t2;
                w2 = c ^ t1;
            end
        end
        return {mul_65537(w0, z[48]), 16'(w1 + z[49]), 16'(w2 + z[50]),
                mul_65537(w3, z[51])};
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver: random stall plus long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check(ciphertext);
        out_stall <= hold_off || ($urandom_range(99) < receiver_idle);
    end

    task automatic write_key(idea_pkg::reg_index_t idx, logic [63:0] v);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_value <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
        if (idx == idea_pkg::REG_KEY_UPPER)
            key_hi = v;
        else
            key_lo = v;
    endtask

    // ignored write to an index beyond the list
    task automatic write_bogus(logic [63:0] v);
        cfg_wr_en <= 1;
        cfg_index <= 2'd3;
        cfg_value <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
    endtask

    // offer one block, waiting through idle gaps and stalls
    task automatic send_block(logic [63:0] blk);
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid  <= 1;
        plaintext <= blk;
        board.note(encrypt_block(blk));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random words biased toward zero and all-ones
    function automatic logic [63:0] rand_block();
        logic [63:0] v;
        v = rand64();
        for (int i = 0; i < 4; i++)
            case ($urandom_range(9))
                0: v[i*16 +: 16] = 16'h0000;
                1: v[i*16 +: 16] = 16'hffff;
                default: ;
            endcase
        return v;
    endfunction

    task automatic random_phase(int n, int s_idle, int r_idle);
        sender_idle   = s_idle;
        receiver_idle = r_idle;
        repeat (n)
            send_block(rand_block());
        drain();
    endtask

    // main sequence
    initial
    begin
        board = new();
        cycles = 0;
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_index = idea_pkg::REG_KEY_UPPER;
        cfg_value = 0;
        in_valid = 0;
        plaintext = 0;
        out_stall = 0;
        hold_off = 0;
        key_hi = 0;
        key_lo = 0;
        sender_idle = 0;
        receiver_idle = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: all-zero key from reset, extreme blocks
        send_block(64'h0);
        send_block(64'hffff_ffff_ffff_ffff);
        send_block(64'h0000_ffff_0000_ffff);
        send_block(64'h0001_0002_0003_0004);
        drain();
        // all-ones key, then the classic test key
        write_key(idea_pkg::REG_KEY_UPPER, 64'hffff_ffff_ffff_ffff);
        write_key(idea_pkg::REG_KEY_LOWER, 64'hffff_ffff_ffff_ffff);
        send_block(64'h0);
        send_block(64'hffff_ffff_ffff_ffff);
        send_block(64'h8000_0000_0000_0001);
        drain();
        write_key(idea_pkg::REG_KEY_UPPER, 64'h0001_0002_0003_0004);
        write_key(idea_pkg::REG_KEY_LOWER, 64'h0005_0006_0007_0008);
        write_bogus(64'hdead_beef_dead_beef);
        send_block(64'h0000_0001_0002_0003);
        send_block(64'h0);
        send_block(64'hffff_0000_ffff_0000);
        drain();

        // random phases with key changes between them
        write_key(idea_pkg::REG_KEY_UPPER, rand64());
        write_key(idea_pkg::REG_KEY_LOWER, rand64());
        random_phase(250, 9, 78);
        write_key(idea_pkg::REG_KEY_UPPER, rand64());
        write_key(idea_pkg::REG_KEY_LOWER, 64'h0);
        random_phase(250, 78, 9);
        write_key(idea_pkg::REG_KEY_UPPER, 64'h0);
        write_key(idea_pkg::REG_KEY_LOWER, rand64());
        random_phase(120, 0, 0);

        // long receiver hold-off while blocks keep coming
        fork
        begin
            hold_off = 1;
            repeat (80) @(posedge clk);
            hold_off = 0;
        end
        join_none
        write_key(idea_pkg::REG_KEY_UPPER, rand64());
        write_key(idea_pkg::REG_KEY_LOWER, rand64());
        random_phase(110, 0, 0);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
